### rtl/core/ifdd_pkg.sv
`default_nettype none

package ifdd_pkg;

  typedef enum logic [2:0] {
    CfgFlag      = 3'd0,
    CfgAddress   = 3'd1,
    CfgCtrlSeq0  = 3'd2,
    CfgCtrlSeq1  = 3'd3,
    CfgEscape    = 3'd4,
    CfgFlagSub   = 3'd5,
    CfgEscSub    = 3'd6,
    CfgExpSeq    = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PhHunt = 5'b00001,
    PhFlag = 5'b00010,
    PhAddr = 5'b00100,
    PhCtrl = 5'b01000,
    PhData = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] address_byte;
    logic [7:0] control_seq0;
    logic [7:0] control_seq1;
    logic [7:0] escape_byte;
    logic [7:0] flag_substitute;
    logic [7:0] escape_substitute;
    logic       expected_seq;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_total;
    logic        seq_ok;
  } res_t;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd     = 1'b1;
  localparam logic [15:0] CountMax = 16'hFFFF;

endpackage

`default_nettype wire

### rtl/core/ifdd_rx_if.sv
`default_nettype none

interface ifdd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/ifdd_res_if.sv
`default_nettype none

interface ifdd_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_total;
  logic        seq_ok;

  modport source (output valid, output kind, output payload_byte, output byte_total,
                  output seq_ok, input ready);
  modport sink (input valid, input kind, input payload_byte, input byte_total,
                input seq_ok, output ready);
endinterface

`default_nettype wire

### rtl/core/ifdd_step.sv
`default_nettype none

module ifdd_step (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic [7:0]  byte_i,
  input  wire ifdd_pkg::cfg_t cfg_i,
  output logic             res_vld_o,
  output ifdd_pkg::res_t   res_o
);
  import ifdd_pkg::*;

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic        seen_q, seen_d;
  logic [15:0] cnt_q, cnt_d;

  logic [7:0]  seen_ctrl;
  logic [7:0]  want_ctrl;
  logic [15:0] cnt_inc;

  assign seen_ctrl = seen_q ? cfg_i.control_seq1 : cfg_i.control_seq0;
  assign want_ctrl = cfg_i.expected_seq ? cfg_i.control_seq1 : cfg_i.control_seq0;
  assign cnt_inc   = (cnt_q != CountMax) ? cnt_q + 16'd1 : cnt_q;

  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    seen_d    = seen_q;
    cnt_d     = cnt_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (esc_q) begin
      if (byte_i == cfg_i.flag_substitute) begin
        esc_d              = 1'b0;
        cnt_d              = cnt_inc;
        res_vld_o          = 1'b1;
        res_o.kind         = KindPayload;
        res_o.payload_byte = cfg_i.flag_byte;
      end else if (byte_i == cfg_i.escape_substitute) begin
        esc_d              = 1'b0;
        cnt_d              = cnt_inc;
        res_vld_o          = 1'b1;
        res_o.kind         = KindPayload;
        res_o.payload_byte = cfg_i.escape_byte;
      end
    end else begin
      case (phase_q)
        PhHunt: begin
          if (byte_i == cfg_i.flag_byte) phase_d = PhFlag;
        end
        PhFlag: begin
          if (byte_i == cfg_i.address_byte) phase_d = PhAddr;
          else if (byte_i == cfg_i.flag_byte) phase_d = PhFlag;
          else phase_d = PhHunt;
        end
        PhAddr: begin
          if (byte_i == cfg_i.control_seq0 || byte_i == cfg_i.control_seq1) begin
            seen_d  = (byte_i != cfg_i.control_seq0);
            phase_d = PhCtrl;
          end else if (byte_i == cfg_i.flag_byte) begin
            phase_d = PhFlag;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhCtrl: begin
          if (byte_i == (cfg_i.address_byte ^ seen_ctrl)) begin
            phase_d = PhData;
            cnt_d   = '0;
            esc_d   = 1'b0;
          end else if (byte_i == cfg_i.flag_byte) begin
            phase_d = PhFlag;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhData: begin
          if (byte_i == cfg_i.flag_byte) begin
            phase_d          = PhHunt;
            cnt_d            = '0;
            esc_d            = 1'b0;
            res_vld_o        = 1'b1;
            res_o.kind       = KindEnd;
            res_o.byte_total = cnt_q;
            res_o.seq_ok     = (seen_ctrl == want_ctrl);
          end else if (byte_i == cfg_i.escape_byte) begin
            esc_d = 1'b1;
          end else begin
            cnt_d              = cnt_inc;
            res_vld_o          = 1'b1;
            res_o.kind         = KindPayload;
            res_o.payload_byte = byte_i;
          end
        end
        default: phase_d = PhHunt;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      esc_q   <= 1'b0;
      seen_q  <= 1'b0;
      cnt_q   <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      seen_q  <= seen_d;
      cnt_q   <= cnt_d;
    end
  end

  a_esc_in_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> phase_q == PhData) else $error("escape pending outside payload");

  a_cnt_header_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhData |-> cnt_q == '0) else $error("count nonzero outside payload");

  a_end_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && res_vld_o && res_o.kind == KindEnd |=> phase_q == PhHunt && cnt_q == '0)
    else $error("end of frame did not return to hunt");

endmodule

`default_nettype wire

### rtl/core/info_frame_deframer_destuffer_unit.sv
// Byte-stuffed information-frame receiver. Takes one link byte per beat on rx_i and
// gives at most one result per byte on res_o: a destuffed payload byte, or at the
// closing flag an end beat with the saturating payload count and the sequence check.
// Bytes are registered on entry, decoded by combinational compare logic and registered
// again on exit; the block sustains one byte per clock unless the result register is
// stalled, which holds back only bytes that produce a result. Registers are written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i by the user only while the block is idle;
// the block does not enforce it. Reset values are the usual flag 0x7E, escape 0x7D.
`default_nettype none

module info_frame_deframer_destuffer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i,
  ifdd_rx_if.sink         rx_i,
  ifdd_res_if.source      res_o
);
  import ifdd_pkg::*;

  cfg_t       cfg_q;
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  res_t       out_q;
  logic       step_vld;
  res_t       step_res;
  logic       adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flag_byte         <= 8'h7E;
      cfg_q.address_byte      <= 8'h03;
      cfg_q.control_seq0      <= 8'h00;
      cfg_q.control_seq1      <= 8'h80;
      cfg_q.escape_byte       <= 8'h7D;
      cfg_q.flag_substitute   <= 8'h5E;
      cfg_q.escape_substitute <= 8'h5D;
      cfg_q.expected_seq      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgFlag:     cfg_q.flag_byte         <= cfg_wdata_i;
        CfgAddress:  cfg_q.address_byte      <= cfg_wdata_i;
        CfgCtrlSeq0: cfg_q.control_seq0      <= cfg_wdata_i;
        CfgCtrlSeq1: cfg_q.control_seq1      <= cfg_wdata_i;
        CfgEscape:   cfg_q.escape_byte       <= cfg_wdata_i;
        CfgFlagSub:  cfg_q.flag_substitute   <= cfg_wdata_i;
        CfgEscSub:   cfg_q.escape_substitute <= cfg_wdata_i;
        CfgExpSeq:   cfg_q.expected_seq      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // decode may proceed unless it has a result and the output register is blocked
  assign adv = in_vld_q && (!out_vld_q || res_o.ready || !step_vld);
  assign rx_i.ready = !in_vld_q || adv;

  ifdd_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .byte_i    (in_byte_q),
    .cfg_i     (cfg_q),
    .res_vld_o (step_vld),
    .res_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rx_i.ready) in_vld_q <= rx_i.valid;
      if (adv && step_vld) out_vld_q <= 1'b1;
      else if (res_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) in_byte_q <= rx_i.rx_byte;
    if (adv && step_vld) out_q <= step_res;
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.kind         = out_q.kind;
  assign res_o.payload_byte = out_q.payload_byte;
  assign res_o.byte_total   = out_q.byte_total;
  assign res_o.seq_ok       = out_q.seq_ok;

  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.kind == KindEnd |-> out_q.payload_byte == 8'h00)
    else $error("end beat carries payload");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.kind == KindPayload |-> out_q.byte_total == '0 && !out_q.seq_ok)
    else $error("payload beat carries end fields");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_o.ready |=> out_vld_q && $stable(out_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
